FILE: rtl/core/signed_int_to_decimal_ascii_top_defines.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_defines.svh
// Assertion macros shared by the decimal text converter modules.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SIDTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define SIDTA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/sidta_pkg.sv
// ----------------------------------------------------------------------------
// sidta_pkg
// Types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sidta_pkg;

  // width of the input value field
  localparam int IN_VALUE_W = 32;
  // width of the character code field
  localparam int CHAR_W     = 6;

  // ASCII codes, masked to the character field
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // binary to BCD conversion: input bits consumed per cycle
  localparam int BITS_PER_STEP = 3;
  // digit value at which the shift-add step adds its correction
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  // front end: accept, classify and convert
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PEND
  } fe_state_t;

  // back end: character emitter
  typedef enum logic [1:0] {
    BE_IDLE,
    BE_SIGN,
    BE_DIGIT
  } be_state_t;

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to its decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
//  channel | ports                                   | flow
//  --------+-----------------------------------------+------------------------
//  input   | start, busy, in_value                   | beat when start & !busy
//  result  | out_strobe, out_char_code, out_last_char| beat on every strobe
//
//  The converter takes 3 magnitude bits a cycle; busy covers the conversion
//  and holds while a finished result waits on a full queue. The emitter
//  sends 1 to 11 characters, one a cycle; items flow at the slower of the
//  two, through a two-entry queue. When idle, the first character follows
//  the conversion, the queue write and the emitter load.
//  Synchronous active-low reset; the receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [sidta_pkg::IN_VALUE_W-1:0] in_value,
  output logic                                    out_strobe,
  output logic [sidta_pkg::CHAR_W-1:0]            out_char_code,
  output logic                                    out_last_char
);
  import sidta_pkg::*;

  // enough digits for 2^(VALUE_BITS-1)
  localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;
  localparam int Q_W  = NDIG * 4 + 1;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  logic [Q_W-1:0] q_wdata;
  logic [Q_W-1:0] q_rdata;

  sidta_front #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sidta_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  sidta_back #(
    .NDIG (NDIG)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

FILE: rtl/core/sidta_front.sv
// ----------------------------------------------------------------------------
// sidta_front
// Accepts a value, splits off the sign and turns the magnitude into packed
// BCD with a shift-add-3 converter, several bits per cycle.
// ----------------------------------------------------------------------------
module sidta_front #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sidta_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [NDIG*4:0]                     q_wdata
);
  import sidta_pkg::*;

  localparam int BCD_W = NDIG * 4;
  localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W = STEPS * BITS_PER_STEP;
  localparam int CNT_W = $clog2(STEPS);

  fe_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PAD_W-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_abs;
  logic                  raw_neg;
  logic [PAD_W-1:0]      mag_step;
  logic [BCD_W-1:0]      bcd_step;
  logic                  accept;

  // sign and magnitude; the most negative value maps to 2^(VALUE_BITS-1)
  assign raw     = VALUE_BITS'($unsigned(in_value));
  assign raw_neg = raw[VALUE_BITS-1];
  assign mag_abs = raw_neg ? (~raw + VALUE_BITS'(1)) : raw;

  // a held result does not block a new beat once the queue takes it
  assign busy   = (state_r == FE_CONV) || ((state_r == FE_PEND) && q_full);
  assign accept = start && !busy;
  assign q_push = (state_r == FE_PEND) && !q_full;
  assign q_wdata = {neg_r, bcd_r};

  // BITS_PER_STEP rounds of add-3 then shift
  always_comb begin
    bcd_step = bcd_r;
    mag_step = mag_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[d*4 +: 4] >= BCD_ADJ_MIN) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + BCD_ADJ;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], mag_step[PAD_W-1]};
      mag_step = {mag_step[PAD_W-2:0], 1'b0};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    case (state_r)
      FE_IDLE: begin
        state_nxt = FE_IDLE;
      end
      FE_CONV: begin
        mag_nxt = mag_step;
        bcd_nxt = bcd_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          state_nxt = FE_PEND;
        end
      end
      FE_PEND: begin
        if (q_push) begin
          state_nxt = FE_IDLE;
        end
      end
      default: begin
        state_nxt = FE_IDLE;
      end
    endcase
    if (accept) begin
      state_nxt = FE_CONV;
      cnt_nxt   = '0;
      mag_nxt   = PAD_W'(mag_abs);
      bcd_nxt   = '0;
      neg_nxt   = raw_neg;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

FILE: rtl/core/sidta_queue.sv
// ----------------------------------------------------------------------------
// sidta_queue
// Two-entry queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_top_defines.svh"

module sidta_queue #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  import sidta_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SIDTA_NEVER(a_no_overflow, push && (count_r == 2'd2), "push into full queue")
  `SIDTA_NEVER(a_no_underflow, pop && (count_r == 2'd0), "pop from empty queue")
  `SIDTA_ASSERT(a_fill_up, (push && !pop) |=> (count_r == $past(count_r) + 2'd1), "fill level")

endmodule

FILE: rtl/core/sidta_back.sv
// ----------------------------------------------------------------------------
// sidta_back
// Emits the sign and the significant BCD digits as ASCII, most significant
// first, one character per cycle.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_top_defines.svh"

module sidta_back #(
  parameter int NDIG = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [NDIG*4:0]               q_rdata,
  output logic                          q_pop,
  output logic                          out_strobe,
  output logic [sidta_pkg::CHAR_W-1:0]  out_char_code,
  output logic                          out_last_char
);
  import sidta_pkg::*;

  localparam int BCD_W = NDIG * 4;
  localparam int IDX_W = $clog2(NDIG);

  be_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;

  logic [IDX_W-1:0]  lead_idx;
  logic [3:0]        digit;
  logic              last_now;

  // highest nonzero digit of the queue head; zero keeps one digit
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (q_rdata[d*4 +: 4] != 4'd0) begin
        lead_idx = IDX_W'(d);
      end
    end
  end

  assign digit    = bcd_r[idx_r*4 +: 4];
  assign last_now = (state_r == BE_DIGIT) && (idx_r == '0);
  // next entry loads as the last character of the current one leaves
  assign q_pop    = q_valid && ((state_r == BE_IDLE) || last_now);

  // output beat
  assign out_strobe    = (state_r != BE_IDLE);
  assign out_char_code = (state_r == BE_SIGN) ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digit));
  assign out_last_char = last_now;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bcd_nxt   = bcd_r;
    case (state_r)
      BE_IDLE: begin
        state_nxt = BE_IDLE;
      end
      BE_SIGN: begin
        state_nxt = BE_DIGIT;
      end
      BE_DIGIT: begin
        if (last_now) begin
          state_nxt = BE_IDLE;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      default: begin
        state_nxt = BE_IDLE;
      end
    endcase
    if (q_pop) begin
      state_nxt = q_rdata[BCD_W] ? BE_SIGN : BE_DIGIT;
      idx_nxt   = lead_idx;
      bcd_nxt   = q_rdata[BCD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    bcd_r <= bcd_nxt;
  end

  `SIDTA_ASSERT(a_sign_then_digit, (state_r == BE_SIGN) |=> (state_r == BE_DIGIT), "sign not followed by digit")
  `SIDTA_NEVER(a_sign_not_last, (state_r == BE_SIGN) && out_last_char, "sign flagged as last")
  `SIDTA_ASSERT(a_idle_after_last, (out_last_char && !q_valid) |=> (state_r == BE_IDLE), "emitter did not stop")

endmodule
